@@ design/backslash_csv_text_unescaper_core_macros.svh @@
// Assertion macros used by the unescaper top level.
`ifndef BACKSLASH_CSV_TEXT_UNESCAPER_CORE_MACROS_SVH
`define BACKSLASH_CSV_TEXT_UNESCAPER_CORE_MACROS_SVH

// Checked on every clock edge outside reset.
`define BCU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BCU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/bcu_pkg.sv @@
// Types and constants shared by the unescaper modules.
package bcu_pkg;

  // Special characters.
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Status codes of a result.
  localparam logic [2:0] STS_OK          = 3'd0;
  localparam logic [2:0] STS_NUL         = 3'd1;
  localparam logic [2:0] STS_ESC_AT_END  = 3'd2;
  localparam logic [2:0] STS_BAD_ESC     = 3'd3;
  localparam logic [2:0] STS_BSL_QUOTE   = 3'd4;
  localparam logic [2:0] STS_QUOTE_END   = 3'd5;
  localparam logic [2:0] STS_UNDOUBLED   = 3'd6;
  localparam logic [2:0] STS_RAW_CHAR    = 3'd7;

  // Configuration register indexes.
  localparam logic CFG_CSV_QUOTES     = 1'b0;
  localparam logic CFG_NUL_TERMINATES = 1'b1;

  // Byte classes found by the front end.
  typedef enum logic [2:0] {
    CLS_OTHER = 3'd0,
    CLS_BSL   = 3'd1,
    CLS_N     = 3'd2,
    CLS_QUOTE = 3'd3,
    CLS_LF    = 3'd4,
    CLS_NUL   = 3'd5
  } byte_class_t;

  // One classified request as it sits in the queue.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    byte_class_t cls;
  } item_t;

  // Configuration seen by the decoder.
  typedef struct packed {
    logic csv_quotes;
    logic nul_terminates;
  } cfg_t;

endpackage

@@ design/bcu_front.sv @@
// Front end: accepts request bytes and classifies them for the decoder.
module bcu_front (
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          is_last,
  input  logic          queue_full,
  output logic          push,
  output bcu_pkg::item_t item
);

  // A request is taken whenever the queue has room.
  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;

  // Classify the byte so the decoder's decisions only look at a small code.
  always_comb begin
    item.data = in_byte;
    item.last = is_last;
    case (in_byte)
      bcu_pkg::CH_BSL:   item.cls = bcu_pkg::CLS_BSL;
      bcu_pkg::CH_N:     item.cls = bcu_pkg::CLS_N;
      bcu_pkg::CH_QUOTE: item.cls = bcu_pkg::CLS_QUOTE;
      bcu_pkg::CH_LF:    item.cls = bcu_pkg::CLS_LF;
      bcu_pkg::CH_NUL:   item.cls = bcu_pkg::CLS_NUL;
      default:           item.cls = bcu_pkg::CLS_OTHER;
    endcase
  end

endmodule

@@ design/bcu_fifo.sv @@
// Short queue of classified requests between front end and decoder.
module bcu_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bcu_pkg::item_t wr_item,
  input  logic           pop,
  output bcu_pkg::item_t rd_item,
  output logic           full,
  output logic           not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bcu_pkg::item_t  entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_item   = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/bcu_back.sv @@
// Decoder: runs the escape state machine and holds the result register.
module bcu_back (
  input  logic           clk,
  input  logic           rst,
  input  bcu_pkg::cfg_t  cfg,
  input  bcu_pkg::item_t item,
  input  logic           item_avail,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           has_byte,
  output logic           text_end,
  output logic [2:0]     status
);

  typedef enum logic [3:0] {
    MODE_NORMAL  = 4'b0001,
    MODE_ESC     = 4'b0010,
    MODE_QUOTE   = 4'b0100,
    MODE_DISCARD = 4'b1000
  } mode_t;

  mode_t      mode;
  mode_t      mode_next;
  logic       emit;
  logic [7:0] res_byte;
  logic       res_has;
  logic       res_end;
  logic [2:0] res_status;
  logic       fail;
  logic       give;
  logic [2:0] fail_status;
  logic [7:0] give_byte;

  // Take the next request when the result register is free or being drained.
  assign pop = item_avail && (!out_valid || out_ready);

  // Decide what the request does in the current mode.
  always_comb begin
    fail        = 1'b0;
    give        = 1'b0;
    fail_status = bcu_pkg::STS_OK;
    give_byte   = item.data;
    mode_next   = mode;
    emit        = 1'b0;
    res_byte    = '0;
    res_has     = 1'b0;
    res_end     = 1'b0;
    res_status  = bcu_pkg::STS_OK;
    case (mode)
      MODE_DISCARD: begin
        if (item.last) begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_ESC: begin
        case (item.cls)
          bcu_pkg::CLS_BSL: begin
            give      = 1'b1;
            give_byte = bcu_pkg::CH_BSL;
          end
          bcu_pkg::CLS_N: begin
            give      = 1'b1;
            give_byte = bcu_pkg::CH_LF;
          end
          bcu_pkg::CLS_QUOTE: begin
            if (cfg.csv_quotes) begin
              fail        = 1'b1;
              fail_status = bcu_pkg::STS_BSL_QUOTE;
            end else begin
              give      = 1'b1;
              give_byte = bcu_pkg::CH_QUOTE;
            end
          end
          default: begin
            fail        = 1'b1;
            fail_status = bcu_pkg::STS_BAD_ESC;
          end
        endcase
      end
      MODE_QUOTE: begin
        if (item.cls == bcu_pkg::CLS_QUOTE) begin
          give      = 1'b1;
          give_byte = bcu_pkg::CH_QUOTE;
        end else begin
          fail        = 1'b1;
          fail_status = bcu_pkg::STS_UNDOUBLED;
        end
      end
      default: begin
        case (item.cls)
          bcu_pkg::CLS_NUL: begin
            if (cfg.nul_terminates) begin
              // Normal end of text on NUL: same shape as a failure, status ok.
              fail        = 1'b1;
              fail_status = bcu_pkg::STS_OK;
            end else begin
              fail        = 1'b1;
              fail_status = bcu_pkg::STS_NUL;
            end
          end
          bcu_pkg::CLS_BSL: begin
            if (item.last) begin
              fail        = 1'b1;
              fail_status = bcu_pkg::STS_ESC_AT_END;
            end else begin
              mode_next = MODE_ESC;
            end
          end
          bcu_pkg::CLS_QUOTE: begin
            if (!cfg.csv_quotes) begin
              fail        = 1'b1;
              fail_status = bcu_pkg::STS_RAW_CHAR;
            end else if (item.last) begin
              fail        = 1'b1;
              fail_status = bcu_pkg::STS_QUOTE_END;
            end else begin
              mode_next = MODE_QUOTE;
            end
          end
          bcu_pkg::CLS_LF: begin
            fail        = 1'b1;
            fail_status = bcu_pkg::STS_RAW_CHAR;
          end
          default: begin
            give = 1'b1;
          end
        endcase
      end
    endcase

    // Shape the result.
    if (fail) begin
      emit       = 1'b1;
      res_end    = 1'b1;
      res_status = fail_status;
      mode_next  = item.last ? MODE_NORMAL : MODE_DISCARD;
    end else if (give) begin
      emit      = 1'b1;
      res_byte  = give_byte;
      res_has   = 1'b1;
      res_end   = item.last;
      mode_next = MODE_NORMAL;
    end
  end

  // Mode register and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_NORMAL;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        mode      <= mode_next;
        out_valid <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_byte <= res_byte;
      has_byte <= res_has;
      text_end <= res_end;
      status   <= res_status;
    end
  end

endmodule

@@ design/backslash_csv_text_unescaper_core.sv @@
// An accepted request is stored in the queue, then popped by the decoder; any result it gives is registered.
// Throughput: one byte per cycle while the queue has room; the decoder state machine retires one queued
// request per cycle whenever the result register is free or being taken.
// A two-entry queue lets the front end keep accepting while a result waits.
// Reset (rst, synchronous): decoder back to normal mode, both configuration registers to 0,
// queue and result register emptied.
`include "backslash_csv_text_unescaper_core_macros.svh"

module backslash_csv_text_unescaper_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       text_end,
  output logic [2:0] status,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_data
);

  bcu_pkg::cfg_t  cfg;
  bcu_pkg::item_t front_item;
  bcu_pkg::item_t queue_item;
  logic           push;
  logic           pop;
  logic           queue_full;
  logic           queue_avail;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bcu_pkg::CFG_CSV_QUOTES:     cfg.csv_quotes     <= cfg_data;
        bcu_pkg::CFG_NUL_TERMINATES: cfg.nul_terminates <= cfg_data;
        default: ;
      endcase
    end
  end

  bcu_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .is_last    (is_last),
    .queue_full (queue_full),
    .push       (push),
    .item       (front_item)
  );

  bcu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_item   (front_item),
    .pop       (pop),
    .rd_item   (queue_item),
    .full      (queue_full),
    .not_empty (queue_avail)
  );

  bcu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (queue_item),
    .item_avail (queue_avail),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .has_byte   (has_byte),
    .text_end   (text_end),
    .status     (status)
  );

  // A decoded character always carries an ok status.
  `BCU_ASSERT(a_byte_ok, out_valid && has_byte |-> status == bcu_pkg::STS_OK, "byte with error status")
  // A result without a character ends the text and carries a zero byte.
  `BCU_ASSERT(a_end_nobyte, out_valid && !has_byte |-> text_end && out_byte == 8'h00, "bad end result")
  // Nothing leaves the block right after reset.
  `BCU_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")

endmodule
